// ===== sv/sensor_frame_crc8_decoder_unit_macros.svh =====
// Assertion macros shared by the sensor frame CRC-8 decoder RTL.
// Included by any module that carries concurrent checks; no other dependencies.
`ifndef SENSOR_FRAME_CRC8_DECODER_UNIT_MACROS_SVH
`define SENSOR_FRAME_CRC8_DECODER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked at each rising clock edge outside reset.
`define SFCRC8_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcrc8 assertion failed");
// Next-cycle implication.
`define SFCRC8_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcrc8 assertion failed");
`else
`define SFCRC8_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define SFCRC8_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/sfcrc8_pkg.sv =====
// Package for the sensor frame CRC-8 decoder: field widths, frame constants,
// shared structs and the CRC-8 byte update function. No dependencies.
package sfcrc8_pkg;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned POS_W    = 3;
   localparam int unsigned RAW_W    = 20;
   localparam int unsigned HUM_W    = 14;
   localparam int unsigned TEMP_W   = 15;

   localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;
   localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;

   // Frame byte positions (position of the next expected byte).
   localparam logic [POS_W-1:0] POS_IDLE   = 3'd0;
   localparam logic [POS_W-1:0] POS_HUM_HI = 3'd1;
   localparam logic [POS_W-1:0] POS_HUM_MD = 3'd2;
   localparam logic [POS_W-1:0] POS_SPLIT  = 3'd3;
   localparam logic [POS_W-1:0] POS_TMP_MD = 3'd4;
   localparam logic [POS_W-1:0] POS_TMP_LO = 3'd5;
   localparam logic [POS_W-1:0] POS_CHECK  = 3'd6;

   localparam int unsigned STATUS_BUSY_BIT = 7;
   localparam int unsigned STATUS_CAL_BIT  = 3;

   // Scale factors: value = raw * scale / 2^20, less TEMP_OFFSET for temperature.
   localparam logic [13:0] HUM_SCALE    = 14'd10000;
   localparam logic [14:0] TEMP_SCALE   = 15'd20000;
   localparam logic [TEMP_W-1:0] TEMP_OFFSET = 15'd5000;
   localparam int unsigned HUM_PROD_W  = RAW_W + 14;
   localparam int unsigned TEMP_PROD_W = RAW_W + 15;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              frame_start;
   } req_item_type;

   typedef struct packed {
      logic             check_done;
      logic             crc_ok;
      logic             busy_flag;
      logic             calibrated_flag;
      logic [RAW_W-1:0] humidity_raw;
      logic [RAW_W-1:0] temperature_raw;
   } frame_info_type;

   // One byte of CRC-8, MSB first, no reflection.
   function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] acc,
                                                     input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = acc ^ b;
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[BYTE_W-1]) begin
            c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[BYTE_W-2:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

// ===== sv/sfcrc8_frame.sv =====
// Frame tracker: byte position, running CRC-8, status byte and raw values.
// Depends on sfcrc8_pkg.
module sfcrc8_frame (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step,
   input  sfcrc8_pkg::req_item_type    item,
   output sfcrc8_pkg::frame_info_type  info
);
   import sfcrc8_pkg::*;

   logic [POS_W-1:0]  pos_ff,    pos_in;
   logic [BYTE_W-1:0] crc_ff,    crc_in;
   logic [BYTE_W-1:0] status_ff, status_in;
   logic [RAW_W-1:0]  hum_ff,    hum_in;
   logic [RAW_W-1:0]  tmp_ff,    tmp_in;

   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      status_in = status_ff;
      hum_in    = hum_ff;
      tmp_in    = tmp_ff;
      if (item.frame_start) begin
         status_in = item.data_byte;
         crc_in    = crc8_update(CRC_INIT, item.data_byte);
         hum_in    = '0;
         tmp_in    = '0;
         pos_in    = POS_HUM_HI;
      end else begin
         unique case (pos_ff)
            POS_HUM_HI: hum_in = {item.data_byte, 12'h000};
            POS_HUM_MD: hum_in = hum_ff | {8'h00, item.data_byte, 4'h0};
            POS_SPLIT: begin
               hum_in = hum_ff | {16'h0000, item.data_byte[7:4]};
               tmp_in = {item.data_byte[3:0], 16'h0000};
            end
            POS_TMP_MD: tmp_in = tmp_ff | {4'h0, item.data_byte, 8'h00};
            POS_TMP_LO: tmp_in = tmp_ff | {12'h000, item.data_byte};
            default: ;
         endcase
         if (pos_ff >= POS_HUM_HI && pos_ff <= POS_TMP_LO) begin
            crc_in = crc8_update(crc_ff, item.data_byte);
            pos_in = pos_ff + POS_W'(1);
         end else begin
            // check byte, idle, or unused code: back to idle
            pos_in = POS_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_IDLE;
         crc_ff    <= CRC_INIT;
         status_ff <= '0;
         hum_ff    <= '0;
         tmp_ff    <= '0;
      end else if (step) begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         status_ff <= status_in;
         hum_ff    <= hum_in;
         tmp_ff    <= tmp_in;
      end
   end

   always_comb begin
      info.check_done      = !item.frame_start && (pos_ff == POS_CHECK);
      info.crc_ok          = (crc_ff == item.data_byte);
      info.busy_flag       = status_ff[STATUS_BUSY_BIT];
      info.calibrated_flag = status_ff[STATUS_CAL_BIT];
      info.humidity_raw    = hum_ff;
      info.temperature_raw = tmp_ff;
   end

endmodule

// ===== sv/sfcrc8_conv.sv =====
// Fixed-point conversion of raw humidity and temperature to hundredths.
// Depends on sfcrc8_pkg.
module sfcrc8_conv (
   input  sfcrc8_pkg::frame_info_type          info,
   output logic [sfcrc8_pkg::HUM_W-1:0]        humidity_centi,
   output logic signed [sfcrc8_pkg::TEMP_W-1:0] temperature_centi
);
   import sfcrc8_pkg::*;

   logic [HUM_PROD_W-1:0]  hum_prod;
   logic [TEMP_PROD_W-1:0] tmp_prod;
   logic [TEMP_W-1:0]      tmp_scaled;

   always_comb begin
      hum_prod   = HUM_PROD_W'(info.humidity_raw) * HUM_PROD_W'(HUM_SCALE);
      tmp_prod   = TEMP_PROD_W'(info.temperature_raw) * TEMP_PROD_W'(TEMP_SCALE);
      tmp_scaled = tmp_prod[TEMP_PROD_W-1:RAW_W];
      // zero both values on a CRC mismatch
      if (info.crc_ok) begin
         humidity_centi    = hum_prod[HUM_PROD_W-1:RAW_W];
         temperature_centi = $signed(tmp_scaled - TEMP_OFFSET);
      end else begin
         humidity_centi    = '0;
         temperature_centi = '0;
      end
   end

endmodule

// ===== sv/sensor_frame_crc8_decoder_unit.sv =====
// Top level of the sensor frame CRC-8 decoder: input register, frame tracker,
// conversion and result register. Depends on sfcrc8_pkg, sfcrc8_frame, sfcrc8_conv.
//
//   port group | direction | carries
//   req_*      | in        | one frame byte and its start flag per request
//   rsp_*      | out       | one decoded reading per completed seven-byte frame
//
// Each request is held in the input register, where the frame tracker
// and the conversion work on it; the reading for a check byte loads into the
// result register, and rsp_valid rises, once that byte leaves the input register.
// With no result stall a new request is taken every cycle.
// Reset (synchronous) empties both registers and returns the tracker to idle
// with the CRC at 0xFF. A stalled result blocks only the check byte behind it;
// other bytes keep flowing into the frame tracker.
`include "sensor_frame_crc8_decoder_unit_macros.svh"
module sensor_frame_crc8_decoder_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [sfcrc8_pkg::BYTE_W-1:0]        req_data_byte,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [sfcrc8_pkg::HUM_W-1:0]         rsp_humidity_centi,
   output logic signed [sfcrc8_pkg::TEMP_W-1:0] rsp_temperature_centi,
   output logic                                 rsp_crc_ok,
   output logic                                 rsp_busy_flag,
   output logic                                 rsp_calibrated_flag
);
   import sfcrc8_pkg::*;

   logic            in_valid_ff, in_valid_in;
   req_item_type    in_item_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [HUM_W-1:0]         hum_ff;
   logic signed [TEMP_W-1:0] tmp_ff;
   logic            crc_ok_ff, busy_ff, cal_ff;

   frame_info_type           info;
   logic [HUM_W-1:0]         hum_conv;
   logic signed [TEMP_W-1:0] tmp_conv;
   logic out_free, advance, load, emit;

   sfcrc8_frame u_frame (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .item  (in_item_ff),
      .info  (info)
   );

   sfcrc8_conv u_conv (
      .info              (info),
      .humidity_centi    (hum_conv),
      .temperature_centi (tmp_conv)
   );

   // Advance the held request unless it is a check byte and the result slot
   // is occupied and stalled.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      advance   = in_valid_ff && (!info.check_done || out_free);
      emit      = advance && info.check_done;
      req_stall = in_valid_ff && !advance;
      load      = req_valid && !req_stall;
      in_valid_in = load ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: load on accept, hold otherwise.
   always_ff @(posedge clock) begin
      if (load) begin
         in_item_ff.data_byte   <= req_data_byte;
         in_item_ff.frame_start <= req_frame_start;
      end
      if (emit) begin
         hum_ff    <= hum_conv;
         tmp_ff    <= tmp_conv;
         crc_ok_ff <= info.crc_ok;
         busy_ff   <= info.busy_flag;
         cal_ff    <= info.calibrated_flag;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_humidity_centi    = hum_ff;
   assign rsp_temperature_centi = tmp_ff;
   assign rsp_crc_ok            = crc_ok_ff;
   assign rsp_busy_flag         = busy_ff;
   assign rsp_calibrated_flag   = cal_ff;

   `SFCRC8_ASSERT_IMPLY(a_fail_zero, clock, reset, rsp_valid_ff && !crc_ok_ff, hum_ff == '0 && tmp_ff == '0)
   `SFCRC8_ASSERT_IMPLY(a_stall_full, clock, reset, req_stall, in_valid_ff && info.check_done)
   `SFCRC8_ASSERT_NEXT(a_emit_shows, clock, reset, emit, rsp_valid_ff)
   `SFCRC8_ASSERT_IMPLY(a_hum_range, clock, reset, rsp_valid_ff, hum_ff <= HUM_W'(9999))

endmodule

// ===== dv/sensor_frame_crc8_decoder_unit_tb.sv =====
// Testbench for sensor_frame_crc8_decoder_unit: sends sensor reply frames and
// checks every decoded reading against a CRC-8 frame tracker written here.
// Depends on sfcrc8_pkg and the decoder RTL.
module sensor_frame_crc8_decoder_unit_tb;
   import sfcrc8_pkg::*;

   // Cap the run well above the slowest correct case: about 2000 requests,
   // each behind a random idle gap, plus result stalls.
   localparam int unsigned CYCLE_LIMIT = 400000;

   // One decoded reading, laid out like the rsp_ payload.
   typedef struct packed {
      logic [HUM_W-1:0]  humidity;
      logic [TEMP_W-1:0] temperature;
      logic              crc_match;
      logic              busy;
      logic              calibrated;
   } reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [BYTE_W-1:0]         req_data_byte = '0;
   logic                      req_frame_start = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [HUM_W-1:0]          rsp_humidity_centi;
   logic signed [TEMP_W-1:0]  rsp_temperature_centi;
   logic                      rsp_crc_ok;
   logic                      rsp_busy_flag;
   logic                      rsp_calibrated_flag;

   // Frame tracker state, reset values as after the block's reset.
   logic [POS_W-1:0]  frame_pos   = POS_IDLE;
   logic [BYTE_W-1:0] crc_run     = CRC_INIT;
   logic [BYTE_W-1:0] status_byte = '0;
   logic [RAW_W-1:0]  hum_raw     = '0;
   logic [RAW_W-1:0]  tmp_raw     = '0;

   reading_type reading_queue[$];
   int unsigned mismatch_count   = 0;
   int unsigned cycle_count      = 0;
   int unsigned sent_frame_bytes = 0;

   // Idling switches: the sender side is read only by the stimulus process,
   // the receiver side by the stall generator.
   bit          req_idle_on = 1'b1;
   bit          rsp_idle_on = 1'b1;
   logic [4:0]  rsp_hold    = '0;

   sensor_frame_crc8_decoder_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_data_byte         (req_data_byte),
      .req_frame_start       (req_frame_start),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_humidity_centi    (rsp_humidity_centi),
      .rsp_temperature_centi (rsp_temperature_centi),
      .rsp_crc_ok            (rsp_crc_ok),
      .rsp_busy_flag         (rsp_busy_flag),
      .rsp_calibrated_flag   (rsp_calibrated_flag)
   );

   always #5 clock = ~clock;

   // Abort a hung run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Result stall generator: alternate random open runs with random stall
   // bursts; hold stall low once idling is switched off.
   always @(posedge clock) begin
      if (!rsp_idle_on) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= '0;
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 5'd1;
      end else if (rsp_stall) begin
         rsp_stall <= 1'b0;
         rsp_hold  <= 5'($urandom_range(0, 30));
      end else begin
         rsp_stall <= 1'b1;
         rsp_hold  <= 5'($urandom_range(0, 18));
      end
   end

   // CRC-8, polynomial 0x31, MSB first, one byte.
   function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] b);
      logic [BYTE_W-1:0] c;
      c = acc ^ b;
      repeat (BYTE_W) c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   // Text of one reading for mismatch reports.
   function automatic string reading_text(input reading_type r);
      return $sformatf("hum %0d temp %0d ok %b busy %b cal %b", r.humidity,
                       $signed(r.temperature), r.crc_match, r.busy, r.calibrated);
   endfunction

   // Advance the frame tracker by one accepted request; on the check byte
   // queue the reading the block must produce.
   task automatic track_byte(input logic [BYTE_W-1:0] b, input logic start);
      reading_type r;
      logic [33:0] hum_prod;
      logic [34:0] tmp_prod;
      logic        advance;
      advance = 1'b1;
      if (start) begin
         // A start always opens a fresh frame, dropping any frame under way.
         status_byte = b;
         crc_run     = crc8_step(CRC_INIT, b);
         hum_raw     = '0;
         tmp_raw     = '0;
         frame_pos   = POS_HUM_HI;
      end else begin
         case (frame_pos)
            POS_HUM_HI: hum_raw = {b, 12'h000};
            POS_HUM_MD: hum_raw = hum_raw | {8'h00, b, 4'h0};
            POS_SPLIT: begin
               hum_raw = hum_raw | {16'h0000, b[7:4]};
               tmp_raw = {b[3:0], 16'h0000};
            end
            POS_TMP_MD: tmp_raw = tmp_raw | {4'h0, b, 8'h00};
            POS_TMP_LO: tmp_raw = tmp_raw | {12'h000, b};
            POS_CHECK: begin
               r.crc_match  = (crc_run == b);
               r.busy       = status_byte[STATUS_BUSY_BIT];
               r.calibrated = status_byte[STATUS_CAL_BIT];
               hum_prod     = hum_raw * 34'd10000;
               tmp_prod     = tmp_raw * 35'd20000;
               // Truncate both conversions; zero both values on a bad CRC.
               r.humidity    = r.crc_match ? hum_prod[33:20] : '0;
               r.temperature = r.crc_match ? tmp_prod[34:20] - 15'd5000 : '0;
               reading_queue.push_back(r);
               frame_pos = POS_IDLE;
               advance   = 1'b0;
            end
            default: begin
               // Idle (or an unused position): drop the byte.
               frame_pos = POS_IDLE;
               advance   = 1'b0;
            end
         endcase
         if (advance) begin
            crc_run   = crc8_step(crc_run, b);
            frame_pos = frame_pos + POS_W'(1);
         end
      end
   endtask

   // Send one request: optionally idle first, then hold the payload until
   // the block takes it.
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic start);
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_frame_start <= start;
      do @(posedge clock); while (req_stall);
      track_byte(b, start);
   endtask

   // Build a reply frame with its check byte, corrupt the check byte by
   // check_flip, and send the first keep bytes of it.
   task automatic send_frame(input logic [BYTE_W-1:0] status,
                             input logic [RAW_W-1:0]  hraw,
                             input logic [RAW_W-1:0]  traw,
                             input logic [BYTE_W-1:0] check_flip,
                             input int unsigned       keep);
      logic [BYTE_W-1:0] frame_bytes [7];
      logic [BYTE_W-1:0] crc;
      frame_bytes[0] = status;
      frame_bytes[1] = hraw[19:12];
      frame_bytes[2] = hraw[11:4];
      frame_bytes[3] = {hraw[3:0], traw[19:16]};
      frame_bytes[4] = traw[15:8];
      frame_bytes[5] = traw[7:0];
      crc = CRC_INIT;
      for (int i = 0; i < 6; i++) crc = crc8_step(crc, frame_bytes[i]);
      frame_bytes[6] = crc ^ check_flip;
      for (int i = 0; i < keep; i++) send_item(frame_bytes[i], i == 0);
      sent_frame_bytes += keep;
   endtask

   // Bytes with no start flag; ignored when no frame is open.
   task automatic send_stray_bytes(input int unsigned count);
      repeat (count) send_item(BYTE_W'($urandom_range(0, 255)), 1'b0);
   endtask

   // Raw value biased toward the conversion edges.
   function automatic logic [RAW_W-1:0] pick_raw();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 20'hFFFFF;
         2: return RAW_W'($urandom_range(0, 63));
         3: return 20'hFFFFF - RAW_W'($urandom_range(0, 127));
         default: return RAW_W'($urandom_range(0, 20'hFFFFF));
      endcase
   endfunction

   task automatic test_directed_cases();
      // Stray byte while idle: no reading.
      send_item(8'h5A, 1'b0);
      // Frame dropped by a new start at the second data byte.
      send_frame(8'h88, 20'h00000, 20'h00000, 8'h00, 2);
      // Lowest readings: zero humidity, -50.00 degrees, both flags set.
      send_frame(8'h88, 20'h00000, 20'h00000, 8'h00, 7);
      // New start arrives where the check byte is expected: no reading.
      send_frame(8'h00, 20'h12345, 20'h6789A, 8'h00, 6);
      // Highest readings, all-ones status and data bytes.
      send_frame(8'hFF, 20'hFFFFF, 20'hFFFFF, 8'h00, 7);
      // Back to idle after the check byte: this one is dropped.
      send_item(8'hC3, 1'b0);
   endtask

   // Mostly well-formed frames with random content and the odd stray byte.
   task automatic test_random_frames();
      int unsigned goal;
      goal = sent_frame_bytes + 900;
      while (sent_frame_bytes < goal) begin
         if ($urandom_range(0, 15) == 0) send_stray_bytes($urandom_range(1, 3));
         send_frame(BYTE_W'($urandom_range(0, 255)), pick_raw(), pick_raw(), 8'h00, 7);
      end
   endtask

   // Bad check bytes, truncated frames and stray bytes between good frames.
   task automatic test_damaged_frames();
      int unsigned goal;
      goal = sent_frame_bytes + 500;
      while (sent_frame_bytes < goal) begin
         case ($urandom_range(0, 9))
            0, 1, 2: send_frame(BYTE_W'($urandom_range(0, 255)), pick_raw(), pick_raw(),
                                BYTE_W'($urandom_range(1, 255)), 7);
            3, 4: send_frame(BYTE_W'($urandom_range(0, 255)), pick_raw(), pick_raw(),
                             8'h00, $urandom_range(1, 6));
            5: send_stray_bytes($urandom_range(1, 4));
            default: send_frame(BYTE_W'($urandom_range(0, 255)), pick_raw(), pick_raw(),
                                8'h00, 7);
         endcase
      end
   endtask

   // Back-to-back requests with the result side always ready.
   task automatic test_full_rate();
      int unsigned goal;
      logic [BYTE_W-1:0] flip;
      req_idle_on = 1'b0;
      rsp_idle_on <= 1'b0;
      goal = sent_frame_bytes + 300;
      while (sent_frame_bytes < goal) begin
         flip = ($urandom_range(0, 3) == 0) ? BYTE_W'($urandom_range(1, 255)) : 8'h00;
         send_frame(BYTE_W'($urandom_range(0, 255)), pick_raw(), pick_raw(), flip, 7);
      end
   endtask

   // Compare each accepted reading with the oldest one queued.
   always @(posedge clock) begin : check_readings
      reading_type want;
      reading_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.humidity    = rsp_humidity_centi;
         got.temperature = rsp_temperature_centi;
         got.crc_match   = rsp_crc_ok;
         got.busy        = rsp_busy_flag;
         got.calibrated  = rsp_calibrated_flag;
         if (reading_queue.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected reading: %s", reading_text(got));
            mismatch_count++;
         end else begin
            want = reading_queue.pop_front();
            if (got !== want) begin
               if (mismatch_count < 10)
                  $display("reading mismatch: expected %s, got %s",
                           reading_text(want), reading_text(got));
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_random_frames();
      test_damaged_frames();
      test_full_rate();
      req_valid <= 1'b0;
      // Drain outstanding readings, then give the pipeline time to show
      // anything extra.
      while (reading_queue.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
